/* hdl/whacc_pkg.sv */
// Shared constants and types of the weighted histogram accumulator.
`timescale 1ns / 1ps

package whacc_pkg;

  localparam int DEF_MAX_BINS  = 256;
  localparam int DEF_SUM_WIDTH = 48;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = 2'd3;

  localparam logic [31:0] RST_MIN_X         = 32'h0000_0000;
  localparam logic [31:0] RST_MAX_X         = 32'h0100_0000;
  localparam logic [31:0] RST_INV_BIN_WIDTH = 32'h0001_0000;
  localparam logic [8:0]  RST_BINS_IN_USE   = 9'd256;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] REGION_UNDER = 2'd0;
  localparam logic [1:0] REGION_BIN   = 2'd1;
  localparam logic [1:0] REGION_OVER  = 2'd2;

  localparam logic [8:0] SEL_UNDER = 9'd256;
  localparam logic [8:0] SEL_OVER  = 9'd257;

  // Control word of one transaction as it leaves the index pipeline.
  typedef struct packed {
    logic       valid;
    logic       is_add;
    logic [1:0] region;
    logic [7:0] bin_number;
    logic       absent;
  } item_ctrl_t;

endpackage

/* hdl/whacc_index.sv */
// Index pipeline: range tests, reciprocal multiply and bin clamp.
`timescale 1ns / 1ps

module whacc_index #(
  parameter int MAX_BINS = whacc_pkg::DEF_MAX_BINS,
  parameter int BIN_W    = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    load,
  input  logic                    cmd,
  input  logic signed [31:0]      x_pos,
  input  logic signed [31:0]      weight,
  input  logic [8:0]              read_sel,
  input  logic signed [31:0]      min_x,
  input  logic signed [31:0]      max_x,
  input  logic [31:0]             inv_bin_width,
  input  logic [8:0]              bins_in_use,
  output whacc_pkg::item_ctrl_t   ctrl,
  output logic [BIN_W-1:0]        addr,
  output logic signed [31:0]      weight_s3
);
  import whacc_pkg::*;

  localparam int LIM_W = $clog2(MAX_BINS + 1);
  localparam logic [31:0] MAX_BINS_32 = 32'(MAX_BINS);

  // Stage 1: input register
  logic               v1;
  logic               cmd1;
  logic signed [31:0] x1;
  logic signed [31:0] w1;
  logic [8:0]         sel1;

  // Stage 2: region and offset from the lower edge
  logic               v2;
  logic               cmd2;
  logic [1:0]         region2;
  logic [31:0]        diff2;
  logic signed [31:0] w2;
  logic [8:0]         sel2;

  // Stage 3: raw bin index
  logic               v3;
  logic               cmd3;
  logic [1:0]         region3;
  logic [31:0]        idx3;
  logic signed [31:0] w3;
  logic [8:0]         sel3;

  logic [1:0]         region_next;
  logic [31:0]        diff_next;
  logic [63:0]        prod;
  logic [LIM_W-1:0]   lim;
  logic [31:0]        clamped;
  logic [31:0]        sel_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= load;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1    <= cmd;
      x1      <= x_pos;
      w1      <= weight;
      sel1    <= read_sel;
      cmd2    <= cmd1;
      region2 <= region_next;
      diff2   <= diff_next;
      w2      <= w1;
      sel2    <= sel1;
      cmd3    <= cmd2;
      region3 <= region2;
      idx3    <= prod[63:32];
      w3      <= w2;
      sel3    <= sel2;
    end
  end

  // Underflow is tested before overflow, so inverted edges never reach a bin.
  always_comb begin
    diff_next = x1 - min_x;
    if (cmd1 == CMD_ADD) begin
      priority if (x1 < min_x) begin
        region_next = REGION_UNDER;
      end else if (x1 > max_x) begin
        region_next = REGION_OVER;
      end else begin
        region_next = REGION_BIN;
      end
    end else begin
      priority if (sel1 == SEL_UNDER) begin
        region_next = REGION_UNDER;
      end else if (sel1 >= SEL_OVER) begin
        region_next = REGION_OVER;
      end else begin
        region_next = REGION_BIN;
      end
    end
  end

  assign prod = 64'(diff2) * 64'(inv_bin_width);

  // Bin limit is bins_in_use held between one and the store depth.
  always_comb begin
    if (bins_in_use == 9'd0) begin
      lim = LIM_W'(1);
    end else if (32'(bins_in_use) > MAX_BINS_32) begin
      lim = LIM_W'(MAX_BINS);
    end else begin
      lim = LIM_W'(bins_in_use);
    end
  end

  assign clamped = (idx3 >= 32'(lim)) ? (32'(lim) - 32'd1) : idx3;
  assign sel_ext = 32'(sel3);

  always_comb begin
    ctrl.valid      = v3;
    ctrl.is_add     = (cmd3 == CMD_ADD);
    ctrl.region     = region3;
    ctrl.bin_number = 8'd0;
    ctrl.absent     = 1'b0;
    addr            = clamped[BIN_W-1:0];
    if (region3 == REGION_BIN) begin
      if (cmd3 == CMD_ADD) begin
        ctrl.bin_number = clamped[7:0];
      end else begin
        ctrl.bin_number = sel3[7:0];
        ctrl.absent     = (sel_ext >= MAX_BINS_32);
        addr            = sel_ext[BIN_W-1:0];
      end
    end
  end

  assign weight_s3 = w3;

endmodule

/* hdl/whacc_accum.sv */
// Bin store, underflow and overflow sums, saturating update and result register.
`timescale 1ns / 1ps

module whacc_accum #(
  parameter int MAX_BINS  = whacc_pkg::DEF_MAX_BINS,
  parameter int SUM_WIDTH = whacc_pkg::DEF_SUM_WIDTH,
  parameter int BIN_W     = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  whacc_pkg::item_ctrl_t       ctrl_s3,
  input  logic [BIN_W-1:0]            addr_s3,
  input  logic signed [31:0]          weight_s3,
  output logic                        out_valid,
  output logic [1:0]                  region,
  output logic [7:0]                  bin_number,
  output logic signed [SUM_WIDTH-1:0] sum_out,
  output logic                        saturated
);
  import whacc_pkg::*;

  localparam logic [SUM_WIDTH-1:0] SAT_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SAT_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic [SUM_WIDTH-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]  bin_valid;

  item_ctrl_t           ctrl4;
  logic [BIN_W-1:0]     addr4;
  logic signed [31:0]   w4;
  logic [SUM_WIDTH-1:0] rd_data4;
  logic                 rd_valid4;

  logic                 byp_v;
  logic [BIN_W-1:0]     byp_addr;
  logic [SUM_WIDTH-1:0] byp_data;

  logic [SUM_WIDTH-1:0] underflow_sum;
  logic [SUM_WIDTH-1:0] overflow_sum;

  logic [SUM_WIDTH-1:0] bin_cur;
  logic [SUM_WIDTH-1:0] cur;
  logic [SUM_WIDTH:0]   ext_sum;
  logic                 clip;
  logic [SUM_WIDTH-1:0] sum_new;
  logic                 upd;
  logic                 wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl4.valid <= 1'b0;
    end else if (adv) begin
      ctrl4.valid <= ctrl_s3.valid;
    end
    if (adv) begin
      ctrl4.is_add     <= ctrl_s3.is_add;
      ctrl4.region     <= ctrl_s3.region;
      ctrl4.bin_number <= ctrl_s3.bin_number;
      ctrl4.absent     <= ctrl_s3.absent;
      addr4            <= addr_s3;
      w4               <= weight_s3;
      rd_data4         <= mem[addr_s3];
      rd_valid4        <= bin_valid[addr_s3];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr4] <= sum_new;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (wr_en) begin
      bin_valid[addr4] <= 1'b1;
    end
  end

  // The write made at the edge that loaded stage 4 is not yet in the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_v <= 1'b0;
    end else if (adv) begin
      byp_v <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp_addr <= addr4;
      byp_data <= sum_new;
    end
  end

  always_comb begin
    if (ctrl4.absent) begin
      bin_cur = '0;
    end else if (byp_v && (byp_addr == addr4)) begin
      bin_cur = byp_data;
    end else if (rd_valid4) begin
      bin_cur = rd_data4;
    end else begin
      bin_cur = '0;
    end
  end

  always_comb begin
    priority if (ctrl4.region == REGION_UNDER) begin
      cur = underflow_sum;
    end else if (ctrl4.region == REGION_OVER) begin
      cur = overflow_sum;
    end else begin
      cur = bin_cur;
    end
  end

  assign ext_sum = {cur[SUM_WIDTH-1], cur} + {{(SUM_WIDTH+1-32){w4[31]}}, w4};
  assign clip    = (ext_sum[SUM_WIDTH] != ext_sum[SUM_WIDTH-1]);
  assign sum_new = clip ? (ext_sum[SUM_WIDTH] ? SAT_MIN : SAT_MAX) : ext_sum[SUM_WIDTH-1:0];

  assign upd   = adv && ctrl4.valid && ctrl4.is_add;
  assign wr_en = upd && (ctrl4.region == REGION_BIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      underflow_sum <= '0;
      overflow_sum  <= '0;
    end else if (upd) begin
      if (ctrl4.region == REGION_UNDER) begin
        underflow_sum <= sum_new;
      end
      if (ctrl4.region == REGION_OVER) begin
        overflow_sum <= sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctrl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      region     <= ctrl4.region;
      bin_number <= ctrl4.bin_number;
      sum_out    <= ctrl4.is_add ? sum_new : cur;
      saturated  <= ctrl4.is_add && clip;
    end
  end

endmodule

/* hdl/weighted_histogram_accumulator.sv */
// Top level of the weighted histogram accumulator.
//
// Input channel (in_valid / in_stall): each transaction either adds a weighted
// sample (cmd add) at Q16.16 position x_pos, or reads one sum chosen by
// read_sel: a bin, the underflow sum or the overflow sum.
// Output channel (out_valid / out_stall): one result per input transaction, in
// order, giving the region, the bin number and the sum after the add or the sum
// read, plus a flag when an add was clipped at the signed sum limit.
// Configuration channel (cfg_valid / cfg_ready, always ready): writes min_x,
// max_x, inv_bin_width and bins_in_use by index; write only while idle.
// A new transaction is accepted every cycle while in_stall is low. Behind the
// input register the stages are the range tests, the 32 x 32 reciprocal
// multiply, the bin clamp with the registered bin store read, and the
// saturating update; back-to-back hits on one bin are forwarded.
// When out_stall holds a waiting result, the whole pipeline holds and
// in_stall rises; a bubble in the result register is filled at once.
// Reset clears all sums, the bin store (through per-bin valid bits) and the
// configuration to its defaults.
`timescale 1ns / 1ps

module weighted_histogram_accumulator #(
  parameter int MAX_BINS  = whacc_pkg::DEF_MAX_BINS,
  parameter int SUM_WIDTH = whacc_pkg::DEF_SUM_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic signed [31:0]                x_pos,
  input  logic signed [31:0]                weight,
  input  logic [8:0]                        read_sel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        region,
  output logic [7:0]                        bin_number,
  output logic signed [SUM_WIDTH-1:0]       sum_out,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [whacc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [whacc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import whacc_pkg::*;

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic signed [31:0] min_x;
  logic signed [31:0] max_x;
  logic [31:0]        inv_bin_width;
  logic [8:0]         bins_in_use;

  logic               adv;
  item_ctrl_t         ctrl_s3;
  logic [BIN_W-1:0]   addr_s3;
  logic signed [31:0] weight_s3;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x         <= RST_MIN_X;
      max_x         <= RST_MAX_X;
      inv_bin_width <= RST_INV_BIN_WIDTH;
      bins_in_use   <= RST_BINS_IN_USE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_X:         min_x         <= cfg_data;
        CFG_MAX_X:         max_x         <= cfg_data;
        CFG_INV_BIN_WIDTH: inv_bin_width <= cfg_data;
        CFG_BINS_IN_USE:   bins_in_use   <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  whacc_index #(
    .MAX_BINS (MAX_BINS),
    .BIN_W    (BIN_W)
  ) u_index (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .load          (in_valid),
    .cmd           (cmd),
    .x_pos         (x_pos),
    .weight        (weight),
    .read_sel      (read_sel),
    .min_x         (min_x),
    .max_x         (max_x),
    .inv_bin_width (inv_bin_width),
    .bins_in_use   (bins_in_use),
    .ctrl          (ctrl_s3),
    .addr          (addr_s3),
    .weight_s3     (weight_s3)
  );

  whacc_accum #(
    .MAX_BINS  (MAX_BINS),
    .SUM_WIDTH (SUM_WIDTH),
    .BIN_W     (BIN_W)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctrl_s3    (ctrl_s3),
    .addr_s3    (addr_s3),
    .weight_s3  (weight_s3),
    .out_valid  (out_valid),
    .region     (region),
    .bin_number (bin_number),
    .sum_out    (sum_out),
    .saturated  (saturated)
  );

endmodule

/* hdl/whacc_checker.sv */
// Port-level checks of the weighted histogram accumulator, bound to the top level.
`timescale 1ns / 1ps

module whacc_checker #(
  parameter int SUM_WIDTH = whacc_pkg::DEF_SUM_WIDTH
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 region,
  input logic [7:0]                 bin_number,
  input logic [SUM_WIDTH-1:0]       sum_out,
  input logic                       saturated
);
  import whacc_pkg::*;

  localparam logic [SUM_WIDTH-1:0] SAT_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SAT_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still valid after reset");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register is empty");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum_out) && $stable(region))
    else $error("stalled result changed");

  a_bin_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && (region != REGION_BIN) |-> (bin_number == 8'd0))
    else $error("bin number set for an underflow or overflow result");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (sum_out == SAT_MAX) || (sum_out == SAT_MIN))
    else $error("saturated result not at a sum limit");

endmodule

bind weighted_histogram_accumulator whacc_checker #(
  .SUM_WIDTH (SUM_WIDTH)
) u_whacc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .region     (region),
  .bin_number (bin_number),
  .sum_out    (sum_out),
  .saturated  (saturated)
);
